[rtl/core/m6502pd_pkg.sv]
package m6502pd_pkg;

  localparam int unsigned OpW     = 8;
  localparam int unsigned AddrW   = 16;
  localparam int unsigned MnemW   = 6;
  localparam int unsigned ModeW   = 4;
  localparam int unsigned LenW    = 2;
  localparam int unsigned BranchBase = 2;

  typedef enum logic [MnemW-1:0] {
    MN_ADC, MN_AND, MN_ASL, MN_BCC, MN_BCS, MN_BEQ, MN_BMI, MN_BNE,
    MN_BPL, MN_BVC, MN_BVS, MN_BIT, MN_BRK, MN_CLC, MN_CLD, MN_CLI,
    MN_CLV, MN_NOP, MN_PHA, MN_PLA, MN_PHP, MN_PLP, MN_RTI, MN_RTS,
    MN_SEC, MN_SED, MN_SEI, MN_TAX, MN_TXA, MN_TAY, MN_TYA, MN_TSX,
    MN_TXS, MN_CMP, MN_CPX, MN_CPY, MN_DEC, MN_DEX, MN_DEY, MN_INX,
    MN_INY, MN_EOR, MN_INC, MN_JMP, MN_JSR, MN_LDA, MN_LDX, MN_LDY,
    MN_LSR, MN_ORA, MN_ROL, MN_ROR, MN_SBC, MN_STA, MN_STX, MN_STY
  } mnem_t;

  typedef enum logic [ModeW-1:0] {
    AM_IMP, AM_ACC, AM_IMM, AM_ZP, AM_ZPX, AM_ZPY, AM_ABS,
    AM_ABSX, AM_ABSY, AM_INDX, AM_INDY, AM_REL, AM_IND
  } mode_t;

  localparam logic [LenW-1:0] LEN_ONE   = 2'd1;
  localparam logic [LenW-1:0] LEN_TWO   = 2'd2;
  localparam logic [LenW-1:0] LEN_THREE = 2'd3;

  typedef struct packed {
    mnem_t mnem;
    mode_t mode;
    logic  known;
  } decode_t;

  function automatic logic [LenW-1:0] len_of_mode(input mode_t mode);
    logic [LenW-1:0] len;
    case (mode)
      AM_IMP, AM_ACC:                    len = LEN_ONE;
      AM_ABS, AM_ABSX, AM_ABSY, AM_IND: len = LEN_THREE;
      default:                           len = LEN_TWO;
    endcase
    return len;
  endfunction

  function automatic decode_t decode_op(input logic [OpW-1:0] op);
    decode_t d;
    d = '{MN_ADC, AM_IMP, 1'b1};
    case (op)
      8'h69: d = '{MN_ADC, AM_IMM,  1'b1};
      8'h65: d = '{MN_ADC, AM_ZP,   1'b1};
      8'h75: d = '{MN_ADC, AM_ZPX,  1'b1};
      8'h6D: d = '{MN_ADC, AM_ABS,  1'b1};
      8'h7D: d = '{MN_ADC, AM_ABSX, 1'b1};
      8'h79: d = '{MN_ADC, AM_ABSY, 1'b1};
      8'h61: d = '{MN_ADC, AM_INDX, 1'b1};
      8'h71: d = '{MN_ADC, AM_INDY, 1'b1};
      8'h29: d = '{MN_AND, AM_IMM,  1'b1};
      8'h25: d = '{MN_AND, AM_ZP,   1'b1};
      8'h35: d = '{MN_AND, AM_ZPX,  1'b1};
      8'h2D: d = '{MN_AND, AM_ABS,  1'b1};
      8'h3D: d = '{MN_AND, AM_ABSX, 1'b1};
      8'h39: d = '{MN_AND, AM_ABSY, 1'b1};
      8'h21: d = '{MN_AND, AM_INDX, 1'b1};
      8'h31: d = '{MN_AND, AM_INDY, 1'b1};
      8'h0A: d = '{MN_ASL, AM_ACC,  1'b1};
      8'h06: d = '{MN_ASL, AM_ZP,   1'b1};
      8'h16: d = '{MN_ASL, AM_ZPX,  1'b1};
      8'h0E: d = '{MN_ASL, AM_ABS,  1'b1};
      8'h1E: d = '{MN_ASL, AM_ABSX, 1'b1};
      8'h90: d = '{MN_BCC, AM_REL,  1'b1};
      8'hB0: d = '{MN_BCS, AM_REL,  1'b1};
      8'hF0: d = '{MN_BEQ, AM_REL,  1'b1};
      8'h30: d = '{MN_BMI, AM_REL,  1'b1};
      8'hD0: d = '{MN_BNE, AM_REL,  1'b1};
      8'h10: d = '{MN_BPL, AM_REL,  1'b1};
      8'h50: d = '{MN_BVC, AM_REL,  1'b1};
      8'h70: d = '{MN_BVS, AM_REL,  1'b1};
      8'h24: d = '{MN_BIT, AM_ZP,   1'b1};
      8'h2C: d = '{MN_BIT, AM_ABS,  1'b1};
      8'h00: d = '{MN_BRK, AM_IMP,  1'b1};
      8'h18: d = '{MN_CLC, AM_IMP,  1'b1};
      8'hD8: d = '{MN_CLD, AM_IMP,  1'b1};
      8'h58: d = '{MN_CLI, AM_IMP,  1'b1};
      8'hB8: d = '{MN_CLV, AM_IMP,  1'b1};
      8'hEA: d = '{MN_NOP, AM_IMP,  1'b1};
      8'h48: d = '{MN_PHA, AM_IMP,  1'b1};
      8'h68: d = '{MN_PLA, AM_IMP,  1'b1};
      8'h08: d = '{MN_PHP, AM_IMP,  1'b1};
      8'h28: d = '{MN_PLP, AM_IMP,  1'b1};
      8'h40: d = '{MN_RTI, AM_IMP,  1'b1};
      8'h60: d = '{MN_RTS, AM_IMP,  1'b1};
      8'h38: d = '{MN_SEC, AM_IMP,  1'b1};
      8'hF8: d = '{MN_SED, AM_IMP,  1'b1};
      8'h78: d = '{MN_SEI, AM_IMP,  1'b1};
      8'hAA: d = '{MN_TAX, AM_IMP,  1'b1};
      8'h8A: d = '{MN_TXA, AM_IMP,  1'b1};
      8'hA8: d = '{MN_TAY, AM_IMP,  1'b1};
      8'h98: d = '{MN_TYA, AM_IMP,  1'b1};
      8'hBA: d = '{MN_TSX, AM_IMP,  1'b1};
      8'h9A: d = '{MN_TXS, AM_IMP,  1'b1};
      8'hC9: d = '{MN_CMP, AM_IMM,  1'b1};
      8'hC5: d = '{MN_CMP, AM_ZP,   1'b1};
      8'hD5: d = '{MN_CMP, AM_ZPX,  1'b1};
      8'hCD: d = '{MN_CMP, AM_ABS,  1'b1};
      8'hDD: d = '{MN_CMP, AM_ABSX, 1'b1};
      8'hD9: d = '{MN_CMP, AM_ABSY, 1'b1};
      8'hC1: d = '{MN_CMP, AM_INDX, 1'b1};
      8'hD1: d = '{MN_CMP, AM_INDY, 1'b1};
      8'hE0: d = '{MN_CPX, AM_IMM,  1'b1};
      8'hE4: d = '{MN_CPX, AM_ZP,   1'b1};
      8'hEC: d = '{MN_CPX, AM_ABS,  1'b1};
      8'hC0: d = '{MN_CPY, AM_IMM,  1'b1};
      8'hC4: d = '{MN_CPY, AM_ZP,   1'b1};
      8'hCC: d = '{MN_CPY, AM_ABS,  1'b1};
      8'hC6: d = '{MN_DEC, AM_ZP,   1'b1};
      8'hD6: d = '{MN_DEC, AM_ZPX,  1'b1};
      8'hCE: d = '{MN_DEC, AM_ABS,  1'b1};
      8'hDE: d = '{MN_DEC, AM_ABSX, 1'b1};
      8'hCA: d = '{MN_DEX, AM_IMP,  1'b1};
      8'h88: d = '{MN_DEY, AM_IMP,  1'b1};
      8'hE8: d = '{MN_INX, AM_IMP,  1'b1};
      8'hC8: d = '{MN_INY, AM_IMP,  1'b1};
      8'h49: d = '{MN_EOR, AM_IMM,  1'b1};
      8'h45: d = '{MN_EOR, AM_ZP,   1'b1};
      8'h55: d = '{MN_EOR, AM_ZPX,  1'b1};
      8'h4D: d = '{MN_EOR, AM_ABS,  1'b1};
      8'h5D: d = '{MN_EOR, AM_ABSX, 1'b1};
      8'h59: d = '{MN_EOR, AM_ABSY, 1'b1};
      8'h41: d = '{MN_EOR, AM_INDX, 1'b1};
      8'h51: d = '{MN_EOR, AM_INDY, 1'b1};
      8'hE6: d = '{MN_INC, AM_ZP,   1'b1};
      8'hF6: d = '{MN_INC, AM_ZPX,  1'b1};
      8'hEE: d = '{MN_INC, AM_ABS,  1'b1};
      8'hFE: d = '{MN_INC, AM_ABSX, 1'b1};
      8'h4C: d = '{MN_JMP, AM_ABS,  1'b1};
      8'h6C: d = '{MN_JMP, AM_IND,  1'b1};
      8'h20: d = '{MN_JSR, AM_ABS,  1'b1};
      8'hA9: d = '{MN_LDA, AM_IMM,  1'b1};
      8'hA5: d = '{MN_LDA, AM_ZP,   1'b1};
      8'hB5: d = '{MN_LDA, AM_ZPX,  1'b1};
      8'hAD: d = '{MN_LDA, AM_ABS,  1'b1};
      8'hBD: d = '{MN_LDA, AM_ABSX, 1'b1};
      8'hB9: d = '{MN_LDA, AM_ABSY, 1'b1};
      8'hA1: d = '{MN_LDA, AM_INDX, 1'b1};
      8'hB1: d = '{MN_LDA, AM_INDY, 1'b1};
      8'hA2: d = '{MN_LDX, AM_IMM,  1'b1};
      8'hA6: d = '{MN_LDX, AM_ZP,   1'b1};
      8'hB6: d = '{MN_LDX, AM_ZPY,  1'b1};
      8'hAE: d = '{MN_LDX, AM_ABS,  1'b1};
      8'hBE: d = '{MN_LDX, AM_ABSY, 1'b1};
      8'hA0: d = '{MN_LDY, AM_IMM,  1'b1};
      8'hA4: d = '{MN_LDY, AM_ZP,   1'b1};
      8'hB4: d = '{MN_LDY, AM_ZPX,  1'b1};
      8'hAC: d = '{MN_LDY, AM_ABS,  1'b1};
      8'hBC: d = '{MN_LDY, AM_ABSX, 1'b1};
      8'h4A: d = '{MN_LSR, AM_ACC,  1'b1};
      8'h46: d = '{MN_LSR, AM_ZP,   1'b1};
      8'h56: d = '{MN_LSR, AM_ZPX,  1'b1};
      8'h4E: d = '{MN_LSR, AM_ABS,  1'b1};
      8'h5E: d = '{MN_LSR, AM_ABSX, 1'b1};
      8'h09: d = '{MN_ORA, AM_IMM,  1'b1};
      8'h05: d = '{MN_ORA, AM_ZP,   1'b1};
      8'h15: d = '{MN_ORA, AM_ZPX,  1'b1};
      8'h0D: d = '{MN_ORA, AM_ABS,  1'b1};
      8'h1D: d = '{MN_ORA, AM_ABSX, 1'b1};
      8'h19: d = '{MN_ORA, AM_ABSY, 1'b1};
      8'h01: d = '{MN_ORA, AM_INDX, 1'b1};
      8'h11: d = '{MN_ORA, AM_INDY, 1'b1};
      8'h2A: d = '{MN_ROL, AM_ACC,  1'b1};
      8'h26: d = '{MN_ROL, AM_ZP,   1'b1};
      8'h36: d = '{MN_ROL, AM_ZPX,  1'b1};
      8'h2E: d = '{MN_ROL, AM_ABS,  1'b1};
      8'h3E: d = '{MN_ROL, AM_ABSX, 1'b1};
      8'h6A: d = '{MN_ROR, AM_ACC,  1'b1};
      8'h66: d = '{MN_ROR, AM_ZP,   1'b1};
      8'h76: d = '{MN_ROR, AM_ZPX,  1'b1};
      8'h6E: d = '{MN_ROR, AM_ABS,  1'b1};
      8'h7E: d = '{MN_ROR, AM_ABSX, 1'b1};
      8'hE9: d = '{MN_SBC, AM_IMM,  1'b1};
      8'hE5: d = '{MN_SBC, AM_ZP,   1'b1};
      8'hF5: d = '{MN_SBC, AM_ZPX,  1'b1};
      8'hED: d = '{MN_SBC, AM_ABS,  1'b1};
      8'hFD: d = '{MN_SBC, AM_ABSX, 1'b1};
      8'hF9: d = '{MN_SBC, AM_ABSY, 1'b1};
      8'hE1: d = '{MN_SBC, AM_INDX, 1'b1};
      8'hF1: d = '{MN_SBC, AM_INDY, 1'b1};
      8'h85: d = '{MN_STA, AM_ZP,   1'b1};
      8'h95: d = '{MN_STA, AM_ZPX,  1'b1};
      8'h8D: d = '{MN_STA, AM_ABS,  1'b1};
      8'h9D: d = '{MN_STA, AM_ABSX, 1'b1};
      8'h99: d = '{MN_STA, AM_ABSY, 1'b1};
      8'h81: d = '{MN_STA, AM_INDX, 1'b1};
      8'h91: d = '{MN_STA, AM_INDY, 1'b1};
      8'h86: d = '{MN_STX, AM_ZP,   1'b1};
      8'h96: d = '{MN_STX, AM_ZPY,  1'b1};
      8'h8E: d = '{MN_STX, AM_ABS,  1'b1};
      8'h84: d = '{MN_STY, AM_ZP,   1'b1};
      8'h94: d = '{MN_STY, AM_ZPX,  1'b1};
      8'h8C: d = '{MN_STY, AM_ABS,  1'b1};
      default: d = '{MN_ADC, AM_IMP, 1'b0};
    endcase
    return d;
  endfunction

endpackage

[rtl/core/m6502pd_if.sv]
interface m6502pd_in_if;
  import m6502pd_pkg::*;

  logic             valid;
  logic             ready;
  logic [OpW-1:0]   opcode_byte;
  logic [OpW-1:0]   operand_low;
  logic [OpW-1:0]   operand_high;
  logic [AddrW-1:0] fetch_address;

  modport source (
    output valid, opcode_byte, operand_low, operand_high, fetch_address,
    input  ready
  );
  modport sink (
    input  valid, opcode_byte, operand_low, operand_high, fetch_address,
    output ready
  );
endinterface

interface m6502pd_out_if;
  import m6502pd_pkg::*;

  logic             valid;
  logic             ready;
  logic [MnemW-1:0] mnemonic_id;
  logic [ModeW-1:0] addressing_mode;
  logic [LenW-1:0]  instruction_length;
  logic [AddrW-1:0] operand_value;
  logic [AddrW-1:0] branch_target;
  logic             unknown_opcode;

  modport source (
    output valid, mnemonic_id, addressing_mode, instruction_length,
           operand_value, branch_target, unknown_opcode,
    input  ready
  );
  modport sink (
    input  valid, mnemonic_id, addressing_mode, instruction_length,
           operand_value, branch_target, unknown_opcode,
    output ready
  );
endinterface

[rtl/core/mos6502_instruction_predecoder.sv]
// Predecodes one NMOS 6502 instruction per beat: mnemonic number, addressing
// mode, length, assembled operand and, for relative branches, the target
// pc+2+offset wrapped to 16 bits. Undocumented opcodes come back as length 1,
// implied, with unknown_opcode set. Throughput is one instruction per clock
// while the consumer takes each result. An input beat is held in the input
// register, then goes through the opcode table lookup and one 16-bit add into
// the result register, which drives the result beat. The input register takes
// a new beat whenever it is empty or its beat moves on to the result register,
// so a result waiting for the consumer stalls the input once both registers
// hold a beat; in_ch.ready follows out_ch.ready combinationally in that case.
module mos6502_instruction_predecoder (
  input  logic            clk,
  input  logic            rst_n,
  m6502pd_in_if.sink      in_ch,
  m6502pd_out_if.source   out_ch
);
  import m6502pd_pkg::*;

  // input register
  logic             s1_valid_r;
  logic [OpW-1:0]   s1_op_r;
  logic [OpW-1:0]   s1_lo_r;
  logic [OpW-1:0]   s1_hi_r;
  logic [AddrW-1:0] s1_pc_r;

  // result register
  logic             s2_valid_r;
  logic [MnemW-1:0] s2_mnem_r;
  logic [ModeW-1:0] s2_mode_r;
  logic [LenW-1:0]  s2_len_r;
  logic [AddrW-1:0] s2_operand_r;
  logic [AddrW-1:0] s2_target_r;
  logic             s2_unknown_r;

  logic             s2_ready;
  logic             s1_load;
  logic             s2_load;

  decode_t          dec;
  logic [LenW-1:0]  len_nxt;
  logic [MnemW-1:0] mnem_nxt;
  logic [ModeW-1:0] mode_nxt;
  logic [AddrW-1:0] operand_nxt;
  logic [AddrW-1:0] target_nxt;
  logic [AddrW-1:0] offset_sext;

  assign s2_ready    = !s2_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s2_ready;
  assign s1_load     = in_ch.valid && in_ch.ready;
  assign s2_load     = s1_valid_r && s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_op_r <= in_ch.opcode_byte;
      s1_lo_r <= in_ch.operand_low;
      s1_hi_r <= in_ch.operand_high;
      s1_pc_r <= in_ch.fetch_address;
    end
  end

  assign offset_sext = {{(AddrW-OpW){s1_lo_r[OpW-1]}}, s1_lo_r};

  always_comb begin
    dec         = decode_op(s1_op_r);
    len_nxt     = LEN_ONE;
    mnem_nxt    = dec.mnem;
    mode_nxt    = dec.mode;
    operand_nxt = '0;
    target_nxt  = '0;
    if (dec.known) begin
      len_nxt = len_of_mode(dec.mode);
      case (len_nxt)
        LEN_THREE: operand_nxt = {s1_hi_r, s1_lo_r};
        LEN_TWO:   operand_nxt = {{(AddrW-OpW){1'b0}}, s1_lo_r};
        default:   operand_nxt = '0;
      endcase
      if (dec.mode == AM_REL) begin
        target_nxt = s1_pc_r + offset_sext + AddrW'(BranchBase);
      end
    end else begin
      // undocumented opcode reads as implied with mnemonic zero
      mnem_nxt = MN_ADC;
      mode_nxt = AM_IMP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_mnem_r    <= mnem_nxt;
      s2_mode_r    <= mode_nxt;
      s2_len_r     <= len_nxt;
      s2_operand_r <= operand_nxt;
      s2_target_r  <= target_nxt;
      s2_unknown_r <= !dec.known;
    end
  end

  assign out_ch.valid              = s2_valid_r;
  assign out_ch.mnemonic_id        = s2_mnem_r;
  assign out_ch.addressing_mode    = s2_mode_r;
  assign out_ch.instruction_length = s2_len_r;
  assign out_ch.operand_value      = s2_operand_r;
  assign out_ch.branch_target      = s2_target_r;
  assign out_ch.unknown_opcode     = s2_unknown_r;

  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load |=> s2_valid_r)
    else $error("decoded beat lost between input and result register");

  a_unknown_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_unknown_r) |->
      (s2_mnem_r == MN_ADC && s2_mode_r == AM_IMP && s2_len_r == LEN_ONE &&
       s2_operand_r == '0 && s2_target_r == '0))
    else $error("unknown opcode result carries decoded fields");

  a_target_rel_only: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_mode_r != AM_REL) |-> (s2_target_r == '0))
    else $error("branch target set outside relative mode");

  a_short_operand: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_len_r != LEN_THREE) |-> (s2_operand_r[AddrW-1:OpW] == '0))
    else $error("operand high byte set on short instruction");

  a_len_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && (s2_mode_r == AM_IMP || s2_mode_r == AM_ACC)) |->
      (s2_len_r == LEN_ONE))
    else $error("one-byte mode with wrong length");

endmodule
